// ===== rtl/vha_pkg.sv =====
// Shared types and constants for the vector heading angle core.
package vha_pkg;

   localparam int GUARD_BITS   = 24;
   localparam int ATAN_ENTRIES = 24;
   localparam int ACC_WIDTH    = 32;
   // headroom above the guarded difference for the CORDIC gain
   localparam int GAIN_BITS    = 3;

   localparam logic [ACC_WIDTH-1:0] TURN_ZERO     = 32'h0000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_QUARTER  = 32'h4000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_HALF     = 32'h8000_0000;
   localparam logic [ACC_WIDTH-1:0] TURN_3QUARTER = 32'hC000_0000;

   // atan(2^-i) as a fraction of a full turn, 2^32 = one turn, truncated
   localparam logic [ACC_WIDTH-1:0] ATAN_TURNS [ATAN_ENTRIES] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517C,
      32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
      32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051
   };

   // angle accumulator plus the on-axis bypass flag
   typedef struct packed {
      logic                 bypass;
      logic [ACC_WIDTH-1:0] z;
   } vha_ang_type;

endpackage

// ===== rtl/vha_if.sv =====
// Valid/ready channel interfaces for requests and responses.
interface vha_req_if #(parameter int COORD_WIDTH = 16);
   logic                          valid;
   logic                          ready;
   logic signed [COORD_WIDTH-1:0] start_x;
   logic signed [COORD_WIDTH-1:0] start_y;
   logic signed [COORD_WIDTH-1:0] end_x;
   logic signed [COORD_WIDTH-1:0] end_y;

   modport source (output valid, start_x, start_y, end_x, end_y, input ready);
   modport sink   (input valid, start_x, start_y, end_x, end_y, output ready);
endinterface

interface vha_rsp_if #(parameter int ANGLE_WIDTH = 16);
   logic                   valid;
   logic                   ready;
   logic [ANGLE_WIDTH-1:0] heading;

   modport source (output valid, heading, input ready);
   modport sink   (input valid, heading, output ready);
endinterface

// ===== rtl/vector_heading_angle_core.sv =====
// Top level of the vector heading angle core: pipelined CORDIC atan2 heading.
// Gives the heading of the vector from start to end, counterclockwise from +y,
// as an unsigned fraction of a full turn (heading / 2^ANGLE_WIDTH). One beat is
// accepted every cycle while no back-pressure holds the pipeline. Each beat
// passes two front-end registers (differences, pre-rotation), one register
// per CORDIC iteration and the rounding output register. Each stage stalls on
// its own, so bubbles are squeezed out and a beat is taken whenever the first
// stage is free, even while a finished result waits. On-axis and zero vectors
// bypass the iterations and are exact.
module vector_heading_angle_core #(
   parameter int COORD_WIDTH  = 16,
   parameter int ANGLE_WIDTH  = 16,
   parameter int CORDIC_STEPS = 16
) (
   input  logic      clock,
   input  logic      reset,
   vha_req_if.sink   req_ch,
   vha_rsp_if.source rsp_ch
);

   localparam int DATA_WIDTH = COORD_WIDTH + 1 + vha_pkg::GUARD_BITS + vha_pkg::GAIN_BITS;

   logic                         v_s [CORDIC_STEPS+1];
   logic                         r_s [CORDIC_STEPS+1];
   logic signed [DATA_WIDTH-1:0] x_s [CORDIC_STEPS+1];
   logic signed [DATA_WIDTH-1:0] y_s [CORDIC_STEPS+1];
   vha_pkg::vha_ang_type         ang_s [CORDIC_STEPS+1];

   vha_prep #(
      .COORD_WIDTH (COORD_WIDTH),
      .DATA_WIDTH  (DATA_WIDTH)
   ) u_prep (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (req_ch.valid),
      .up_ready   (req_ch.ready),
      .up_start_x (req_ch.start_x),
      .up_start_y (req_ch.start_y),
      .up_end_x   (req_ch.end_x),
      .up_end_y   (req_ch.end_y),
      .dn_valid   (v_s[0]),
      .dn_ready   (r_s[0]),
      .dn_x       (x_s[0]),
      .dn_y       (y_s[0]),
      .dn_ang     (ang_s[0])
   );

   for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_stage
      vha_stage #(
         .DATA_WIDTH (DATA_WIDTH),
         .SHIFT      (i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .up_valid (v_s[i]),
         .up_ready (r_s[i]),
         .up_x     (x_s[i]),
         .up_y     (y_s[i]),
         .up_ang   (ang_s[i]),
         .dn_valid (v_s[i+1]),
         .dn_ready (r_s[i+1]),
         .dn_x     (x_s[i+1]),
         .dn_y     (y_s[i+1]),
         .dn_ang   (ang_s[i+1])
      );
   end

   vha_round #(
      .ANGLE_WIDTH (ANGLE_WIDTH)
   ) u_round (
      .clock      (clock),
      .reset      (reset),
      .up_valid   (v_s[CORDIC_STEPS]),
      .up_ready   (r_s[CORDIC_STEPS]),
      .up_ang     (ang_s[CORDIC_STEPS]),
      .dn_valid   (rsp_ch.valid),
      .dn_ready   (rsp_ch.ready),
      .dn_heading (rsp_ch.heading)
   );

   // an empty pre-rotation register always lets a beat in
   a_empty_accepts: assert property (@(posedge clock) disable iff (reset)
      !v_s[0] |-> req_ch.ready)
      else $error("front stage ready chain broken");

   a_ready_when_drained: assert property (@(posedge clock) disable iff (reset)
      (!v_s[CORDIC_STEPS] && !rsp_ch.valid) |-> r_s[CORDIC_STEPS])
      else $error("rounding stage not ready while empty");

   // bypassed results are exact multiples of a quarter turn
   a_bypass_exact: assert property (@(posedge clock) disable iff (reset)
      (v_s[CORDIC_STEPS] && ang_s[CORDIC_STEPS].bypass) |->
         (ang_s[CORDIC_STEPS].z[vha_pkg::ACC_WIDTH-3:0] == '0))
      else $error("on-axis bypass angle disturbed");

   a_reset_clears: assert property (@(posedge clock)
      $past(reset) |-> (!rsp_ch.valid && !v_s[0]))
      else $error("pipeline valid set after reset");

endmodule

// ===== rtl/vha_prep.sv =====
// Front end: coordinate differences, half-turn pre-rotation and on-axis detection.
module vha_prep #(
   parameter int COORD_WIDTH = 16,
   parameter int DATA_WIDTH  = 44
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          up_valid,
   output logic                          up_ready,
   input  logic signed [COORD_WIDTH-1:0] up_start_x,
   input  logic signed [COORD_WIDTH-1:0] up_start_y,
   input  logic signed [COORD_WIDTH-1:0] up_end_x,
   input  logic signed [COORD_WIDTH-1:0] up_end_y,
   output logic                          dn_valid,
   input  logic                          dn_ready,
   output logic signed [DATA_WIDTH-1:0]  dn_x,
   output logic signed [DATA_WIDTH-1:0]  dn_y,
   output vha_pkg::vha_ang_type          dn_ang
);

   localparam int DW = COORD_WIDTH + 1;
   localparam int EXT = DATA_WIDTH - DW;

   // stage A: differences
   logic                 diff_valid_ff;
   logic signed [DW-1:0] dx_ff, dy_ff, dx_in, dy_in;
   logic                 diff_ready;

   // stage B: rotated, guarded vector
   logic                         vec_valid_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, y_ff, x_in, y_in;
   vha_pkg::vha_ang_type         ang_ff, ang_in;

   logic signed [DATA_WIDTH-1:0] dx_ext, dy_ext;
   logic                         dy_neg;

   assign diff_ready = !vec_valid_ff || dn_ready;
   assign up_ready   = !diff_valid_ff || diff_ready;

   assign dx_in = DW'(up_end_x) - DW'(up_start_x);
   assign dy_in = DW'(up_end_y) - DW'(up_start_y);

   always_ff @(posedge clock) begin
      if (reset) begin
         diff_valid_ff <= 1'b0;
      end else if (up_ready) begin
         diff_valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
      end
   end

   assign dx_ext = {{EXT{dx_ff[DW-1]}}, dx_ff};
   assign dy_ext = {{EXT{dy_ff[DW-1]}}, dy_ff};
   assign dy_neg = dy_ff[DW-1];

   always_comb begin
      ang_in.bypass = 1'b0;
      ang_in.z      = vha_pkg::TURN_ZERO;
      if (dy_neg) begin
         // left half plane: rotate by a half turn first
         x_in     = (-dy_ext) <<< vha_pkg::GUARD_BITS;
         y_in     = dx_ext <<< vha_pkg::GUARD_BITS;
         ang_in.z = vha_pkg::TURN_HALF;
      end else begin
         x_in = dy_ext <<< vha_pkg::GUARD_BITS;
         y_in = (-dx_ext) <<< vha_pkg::GUARD_BITS;
      end
      priority if (dx_ff == '0) begin
         ang_in.bypass = 1'b1;
         ang_in.z      = dy_neg ? vha_pkg::TURN_HALF : vha_pkg::TURN_ZERO;
      end else if (dy_ff == '0) begin
         ang_in.bypass = 1'b1;
         ang_in.z      = dx_ff[DW-1] ? vha_pkg::TURN_QUARTER : vha_pkg::TURN_3QUARTER;
      end else begin
         ang_in.bypass = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vec_valid_ff <= 1'b0;
      end else if (diff_ready) begin
         vec_valid_ff <= diff_valid_ff;
      end
      if (diff_ready && diff_valid_ff) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         ang_ff <= ang_in;
      end
   end

   assign dn_valid = vec_valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_ang   = ang_ff;

endmodule

// ===== rtl/vha_stage.sv =====
// One registered CORDIC vectoring iteration.
module vha_stage #(
   parameter int DATA_WIDTH = 44,
   parameter int SHIFT      = 0
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         up_valid,
   output logic                         up_ready,
   input  logic signed [DATA_WIDTH-1:0] up_x,
   input  logic signed [DATA_WIDTH-1:0] up_y,
   input  vha_pkg::vha_ang_type         up_ang,
   output logic                         dn_valid,
   input  logic                         dn_ready,
   output logic signed [DATA_WIDTH-1:0] dn_x,
   output logic signed [DATA_WIDTH-1:0] dn_y,
   output vha_pkg::vha_ang_type         dn_ang
);

   logic                         valid_ff;
   logic signed [DATA_WIDTH-1:0] x_ff, y_ff, x_in, y_in;
   vha_pkg::vha_ang_type         ang_ff, ang_in;
   logic signed [DATA_WIDTH-1:0] xs, ys;

   assign up_ready = !valid_ff || dn_ready;

   assign xs = up_x >>> SHIFT;
   assign ys = up_y >>> SHIFT;

   always_comb begin
      ang_in = up_ang;
      if (up_y[DATA_WIDTH-1]) begin
         x_in = up_x - ys;
         y_in = up_y + xs;
         if (!up_ang.bypass) ang_in.z = up_ang.z - vha_pkg::ATAN_TURNS[SHIFT];
      end else begin
         x_in = up_x + ys;
         y_in = up_y - xs;
         if (!up_ang.bypass) ang_in.z = up_ang.z + vha_pkg::ATAN_TURNS[SHIFT];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         x_ff   <= x_in;
         y_ff   <= y_in;
         ang_ff <= ang_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_x     = x_ff;
   assign dn_y     = y_ff;
   assign dn_ang   = ang_ff;

endmodule

// ===== rtl/vha_round.sv =====
// Output register: rounds the turn accumulator to the heading width.
module vha_round #(
   parameter int ANGLE_WIDTH = 16
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   up_valid,
   output logic                   up_ready,
   input  vha_pkg::vha_ang_type   up_ang,
   output logic                   dn_valid,
   input  logic                   dn_ready,
   output logic [ANGLE_WIDTH-1:0] dn_heading
);

   localparam int AW = vha_pkg::ACC_WIDTH;

   logic                   valid_ff;
   logic [ANGLE_WIDTH-1:0] heading_ff, heading_in;
   logic [AW:0]            sum;

   assign up_ready = !valid_ff || dn_ready;

   // round half up; a carry into a full turn wraps to zero
   assign sum        = {1'b0, up_ang.z} + ((AW+1)'(1) << (AW - 1 - ANGLE_WIDTH));
   assign heading_in = sum[AW-1 -: ANGLE_WIDTH];

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (up_ready) begin
         valid_ff <= up_valid;
      end
      if (up_ready && up_valid) begin
         heading_ff <= heading_in;
      end
   end

   assign dn_valid   = valid_ff;
   assign dn_heading = heading_ff;

endmodule
